/* src/bresenham_line_planar_pixels_core_macros.svh */
// Assertion macros used by the line generator checker.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef BRESENHAM_LINE_PLANAR_PIXELS_CORE_MACROS_SVH
`define BRESENHAM_LINE_PLANAR_PIXELS_CORE_MACROS_SVH

// Same-cycle implication.
`define BLPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line generator check failed");

// Next-cycle implication.
`define BLPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line generator check failed");

`endif

/* src/blpp_pkg.sv */
// Shared types and constants of the Bresenham line pixel generator.
// No dependencies; used by the pixel and config interfaces, all modules and the checker.
`timescale 1ns / 1ps

package blpp_pkg;

	// Request kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	// Frame buffer layout
	localparam int COLOR_W       = 4;
	localparam int BYTE_OFFSET_W = 16;
	localparam int PIX_PER_BYTE_LOG2 = 3;
	localparam int LIN_W         = BYTE_OFFSET_W + PIX_PER_BYTE_LOG2;
	localparam logic [PIX_PER_BYTE_LOG2-1:0] MASK_MSB = 3'd7;

	typedef logic [COLOR_W-1:0] color_t;

	// Control of the stepper's output stage
	typedef struct packed {
		logic valid;
		logic last;
	} stage_ctl_t;

endpackage

/* src/blpp_cmd_if.sv */
// Request channel of the line generator: start or step, with the two endpoints.
// Depends on nothing but its own COORD_BITS parameter.
`timescale 1ns / 1ps

interface blpp_cmd_if #(parameter int COORD_BITS = 12);
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

/* src/blpp_pix_if.sv */
// Pixel result channel of the line generator.
// Depends on blpp_pkg for the frame buffer field widths.
`timescale 1ns / 1ps

interface blpp_pix_if #(parameter int COORD_BITS = 12);
	logic                                 valid;
	logic                                 ready;
	logic signed [COORD_BITS-1:0]         pixel_x;
	logic signed [COORD_BITS-1:0]         pixel_y;
	logic                                 on_screen;
	logic [blpp_pkg::BYTE_OFFSET_W-1:0]   byte_offset;
	logic [7:0]                           bit_mask;
	blpp_pkg::color_t                     plane_bits;
	logic                                 last;

	modport source (output valid, pixel_x, pixel_y, on_screen, byte_offset, bit_mask,
		plane_bits, last, input ready);
	modport sink   (input valid, pixel_x, pixel_y, on_screen, byte_offset, bit_mask,
		plane_bits, last, output ready);
endinterface

/* src/blpp_cfg_if.sv */
// Configuration write channel: carries the drawing color.
// Depends on blpp_pkg for the color type.
`timescale 1ns / 1ps

interface blpp_cfg_if;
	logic             valid;
	logic             ready;
	blpp_pkg::color_t draw_color;

	modport source (output valid, draw_color, input ready);
	modport sink   (input valid, draw_color, output ready);
endinterface

/* src/blpp_stepper.sv */
// Bresenham stepper: holds the line state, takes start/step requests and
// registers the next pixel coordinates. Depends on blpp_pkg.
`timescale 1ns / 1ps

module blpp_stepper #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output blpp_pkg::stage_ctl_t         ctl_s1,
	output logic signed [COORD_BITS-1:0] pixel_x_s1,
	output logic signed [COORD_BITS-1:0] pixel_y_s1,
	input  logic                         ds_ready
);
	import blpp_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int EW = COORD_BITS + 2;
	localparam logic [CW-1:0] ONE = CW'(1);

	logic signed [CW-1:0] cur_x_q, cur_y_q, target_x_q, target_y_q;
	logic [CW-1:0]        span_x_q;
	logic signed [CW:0]   span_y_neg_q;
	logic                 dir_x_neg_q, dir_y_neg_q;
	logic signed [EW-1:0] err_q;
	logic                 line_active_q;

	logic signed [CW:0]   ddx, ddy, abs_x, span_y_neg_new;
	logic [CW-1:0]        span_x_new;
	logic signed [EW-1:0] err_start, err_step, add_x, add_y, err_new;
	logic signed [EW:0]   e2;
	logic                 take_x, take_y, is_start, fire, emit, at_end;
	logic signed [CW-1:0] step_x, step_y, nx, ny, tx, ty;

	// start setup
	assign ddx            = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
	assign ddy            = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
	assign abs_x          = ddx[CW] ? -ddx : ddx;
	assign span_x_new     = abs_x[CW-1:0];
	assign span_y_neg_new = ddy[CW] ? ddy : -ddy;
	assign err_start      = {2'b00, span_x_new} + {span_y_neg_new[CW], span_y_neg_new};

	// one error update
	assign e2     = {err_q, 1'b0};
	assign take_x = e2 >= $signed({{2{span_y_neg_q[CW]}}, span_y_neg_q});
	assign take_y = e2 <= $signed({3'b000, span_x_q});
	assign add_x  = take_x ? {span_y_neg_q[CW], span_y_neg_q} : '0;
	assign add_y  = take_y ? $signed({2'b00, span_x_q}) : '0;
	assign err_step = err_q + add_x + add_y;
	assign step_x = dir_x_neg_q ? cur_x_q - ONE : cur_x_q + ONE;
	assign step_y = dir_y_neg_q ? cur_y_q - ONE : cur_y_q + ONE;

	assign is_start = (kind == KIND_START);
	assign nx       = is_start ? start_x : (take_x ? step_x : cur_x_q);
	assign ny       = is_start ? start_y : (take_y ? step_y : cur_y_q);
	assign tx       = is_start ? end_x : target_x_q;
	assign ty       = is_start ? end_y : target_y_q;
	assign err_new  = is_start ? err_start : err_step;
	assign at_end   = (nx == tx) && (ny == ty);

	assign in_ready = !ctl_s1.valid || ds_ready;
	assign fire     = in_valid && in_ready;
	// a step with no line in progress is taken and dropped
	assign emit     = fire && (is_start || line_active_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1        <= '0;
			line_active_q <= 1'b0;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			target_x_q    <= '0;
			target_y_q    <= '0;
			span_x_q      <= '0;
			span_y_neg_q  <= '0;
			dir_x_neg_q   <= 1'b0;
			dir_y_neg_q   <= 1'b0;
			err_q         <= '0;
		end else begin
			if (in_ready) begin
				ctl_s1.valid <= emit;
			end
			if (emit) begin
				ctl_s1.last   <= at_end;
				line_active_q <= !at_end;
				cur_x_q       <= nx;
				cur_y_q       <= ny;
				err_q         <= err_new;
				if (is_start) begin
					target_x_q   <= end_x;
					target_y_q   <= end_y;
					span_x_q     <= span_x_new;
					span_y_neg_q <= span_y_neg_new;
					dir_x_neg_q  <= !(start_x < end_x);
					dir_y_neg_q  <= !(start_y < end_y);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x_s1 <= nx;
			pixel_y_s1 <= ny;
		end
	end

endmodule

/* src/blpp_pixel_fmt.sv */
// Pixel formatter: screen clip, plane byte address, bit mask and color,
// held in the result register. Depends on blpp_pkg.
`timescale 1ns / 1ps

module blpp_pixel_fmt #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480,
	parameter int COORD_BITS    = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  blpp_pkg::stage_ctl_t                 ctl_s1,
	input  logic signed [COORD_BITS-1:0]         pixel_x_s1,
	input  logic signed [COORD_BITS-1:0]         pixel_y_s1,
	output logic                                 ready_s1,
	input  blpp_pkg::color_t                     draw_color,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [COORD_BITS-1:0]         pixel_x,
	output logic signed [COORD_BITS-1:0]         pixel_y,
	output logic                                 on_screen,
	output logic [blpp_pkg::BYTE_OFFSET_W-1:0]   byte_offset,
	output logic [7:0]                           bit_mask,
	output blpp_pkg::color_t                     plane_bits,
	output logic                                 last
);
	import blpp_pkg::*;

	logic signed [31:0]         x_ext, y_ext;
	logic                       vis;
	logic [LIN_W-1:0]           lin;
	logic [7:0]                 mask;
	logic                       valid_s2;
	logic signed [COORD_BITS-1:0] px_s2, py_s2;
	logic                       vis_s2, last_s2;
	logic [BYTE_OFFSET_W-1:0]   offset_s2;
	logic [7:0]                 mask_s2;
	color_t                     color_s2;

	assign x_ext = 32'(pixel_x_s1);
	assign y_ext = 32'(pixel_y_s1);
	assign vis   = (x_ext >= 0) && (x_ext < SCREEN_WIDTH) &&
	               (y_ext >= 0) && (y_ext < SCREEN_HEIGHT);

	// only the low address bits are kept, so the product wraps harmlessly
	assign lin  = LIN_W'($unsigned(pixel_y_s1)) * LIN_W'(SCREEN_WIDTH) +
	              LIN_W'($unsigned(pixel_x_s1));
	assign mask = 8'h01 << (MASK_MSB - pixel_x_s1[PIX_PER_BYTE_LOG2-1:0]);

	assign ready_s1 = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && ctl_s1.valid) begin
			px_s2     <= pixel_x_s1;
			py_s2     <= pixel_y_s1;
			vis_s2    <= vis;
			last_s2   <= ctl_s1.last;
			offset_s2 <= vis ? lin[LIN_W-1:PIX_PER_BYTE_LOG2] : '0;
			mask_s2   <= vis ? mask : '0;
			color_s2  <= vis ? draw_color : '0;
		end
	end

	assign out_valid   = valid_s2;
	assign pixel_x     = px_s2;
	assign pixel_y     = py_s2;
	assign on_screen   = vis_s2;
	assign byte_offset = offset_s2;
	assign bit_mask    = mask_s2;
	assign plane_bits  = color_s2;
	assign last        = last_s2;

endmodule

/* src/bresenham_line_planar_pixels_core.sv */
// Bresenham line generator for a 4-plane, 1-bit-per-plane frame buffer.
// An accepted request reaches its pixel through the stepper stage and the result register.
// Throughput: one request per cycle, set by the one error update, unless pix stalls.
// A step request with no line in progress is accepted and yields no pixel.
// Reset (arst_n low, asynchronous) empties both stages, idles the line, zeroes draw_color.
`timescale 1ns / 1ps

module bresenham_line_planar_pixels_core #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480,
	parameter int COORD_BITS    = 12
) (
	input logic        clk,
	input logic        arst_n,
	blpp_cmd_if.sink   cmd,
	blpp_pix_if.source pix,
	blpp_cfg_if.sink   cfg
);
	import blpp_pkg::*;

	// Drawing color register. The user must write it only while the generator is idle, as
	// the block does not enforce it; the formatter samples it directly with no shadow copy.
	color_t draw_color_q;

	// Stepper -> formatter stage
	stage_ctl_t                   ctl_s1;
	logic signed [COORD_BITS-1:0] pixel_x_s1;
	logic signed [COORD_BITS-1:0] pixel_y_s1;
	logic                         ready_s1;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_color_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			draw_color_q <= cfg.draw_color;
		end
	end

	// Stage 1: line state and the next pixel position. It takes a new
	// request whenever its output slot is free or is moving on.
	blpp_stepper #(
		.COORD_BITS (COORD_BITS)
	) u_stepper (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cmd.valid),
		.in_ready   (cmd.ready),
		.kind       (cmd.kind),
		.start_x    (cmd.start_x),
		.start_y    (cmd.start_y),
		.end_x      (cmd.end_x),
		.end_y      (cmd.end_y),
		.ctl_s1     (ctl_s1),
		.pixel_x_s1 (pixel_x_s1),
		.pixel_y_s1 (pixel_y_s1),
		.ds_ready   (ready_s1)
	);

	// Stage 2: clipping, byte address, mask and color; this is the result register,
	// which holds its pixel while a stalled consumer backs up into the stepper.
	blpp_pixel_fmt #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.COORD_BITS    (COORD_BITS)
	) u_pixel_fmt (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_s1      (ctl_s1),
		.pixel_x_s1  (pixel_x_s1),
		.pixel_y_s1  (pixel_y_s1),
		.ready_s1    (ready_s1),
		.draw_color  (draw_color_q),
		.out_valid   (pix.valid),
		.out_ready   (pix.ready),
		.pixel_x     (pix.pixel_x),
		.pixel_y     (pix.pixel_y),
		.on_screen   (pix.on_screen),
		.byte_offset (pix.byte_offset),
		.bit_mask    (pix.bit_mask),
		.plane_bits  (pix.plane_bits),
		.last        (pix.last)
	);

endmodule

/* src/blpp_checker.sv */
// Port-level checks of the line generator, bound to the top level.
// Depends on blpp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bresenham_line_planar_pixels_core_macros.svh"

module blpp_checker #(
	parameter int COORD_BITS = 12
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                cmd_valid,
	input logic                                cmd_ready,
	input logic                                cmd_kind,
	input logic                                pix_valid,
	input logic                                pix_ready,
	input logic signed [COORD_BITS-1:0]        pixel_x,
	input logic                                on_screen,
	input logic [blpp_pkg::BYTE_OFFSET_W-1:0]  byte_offset,
	input logic [7:0]                          bit_mask,
	input blpp_pkg::color_t                    plane_bits,
	input logic                                last
);
	import blpp_pkg::*;

	// after an accepted start, a pixel is valid past the stepper stage and the result register
	`BLPP_ASSERT_NXT(a_start_yields_pixel, clk, arst_n, cmd_valid && cmd_ready && cmd_kind == KIND_START, ##1 pix_valid)
	// a stalled pixel holds
	`BLPP_ASSERT_NXT(a_pix_hold, clk, arst_n, pix_valid && !pix_ready, pix_valid && $stable(pixel_x) && $stable(byte_offset) && $stable(last))
	// off-screen pixels write nothing
	`BLPP_ASSERT_IMP(a_offscreen_blank, clk, arst_n, pix_valid && !on_screen, byte_offset == '0 && bit_mask == '0 && plane_bits == '0)
	// on-screen pixels touch exactly one bit
	`BLPP_ASSERT_IMP(a_mask_onehot, clk, arst_n, pix_valid && on_screen, $onehot(bit_mask))

endmodule

bind bresenham_line_planar_pixels_core blpp_checker #(
	.COORD_BITS (COORD_BITS)
) u_blpp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_kind    (cmd.kind),
	.pix_valid   (pix.valid),
	.pix_ready   (pix.ready),
	.pixel_x     (pix.pixel_x),
	.on_screen   (pix.on_screen),
	.byte_offset (pix.byte_offset),
	.bit_mask    (pix.bit_mask),
	.plane_bits  (pix.plane_bits),
	.last        (pix.last)
);

/* tb/bresenham_line_planar_pixels_core_tb.sv */
// Self-checking regression of bresenham_line_planar_pixels_core: start/step requests in, pixels out.
// Depends on blpp_pkg and the blpp_cmd_if, blpp_pix_if and blpp_cfg_if interfaces of the RTL.
`timescale 1ns / 1ps

module bresenham_line_planar_pixels_core_tb;
	import blpp_pkg::*;

	localparam int SCREEN_W = 640;
	localparam int SCREEN_H = 480;
	localparam int COORD_W  = 12;
	localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
	localparam int COORD_MIN = -(1 << (COORD_W - 1));

	// Two-stage pipe per the RTL header; a few spare cycles on top.
	localparam int SETTLE_CYCLES = 8;
	localparam int RAND_ITEMS_PER_PHASE = 185;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;

	// One request on the command channel.
	typedef struct {
		logic                      kind;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] ex;
		logic signed [COORD_W-1:0] ey;
	} line_req_t;

	// One pixel on the result channel.
	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      on_screen;
		logic [BYTE_OFFSET_W-1:0]  byte_offset;
		logic [7:0]                bit_mask;
		color_t                    plane_bits;
		logic                      last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	blpp_cmd_if #(.COORD_BITS(COORD_W)) cmd ();
	blpp_pix_if #(.COORD_BITS(COORD_W)) pix ();
	blpp_cfg_if cfg ();

	bresenham_line_planar_pixels_core #(
		.SCREEN_WIDTH (SCREEN_W),
		.SCREEN_HEIGHT(SCREEN_H),
		.COORD_BITS   (COORD_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.pix   (pix),
		.cfg   (cfg)
	);

	// TB-side drive registers; all updated by NBA at posedge, known from time 0.
	logic      req_valid = 1'b0;
	line_req_t req_offer = '{KIND_STEP, '0, '0, '0, '0};
	logic      pix_take  = 1'b0;
	logic      cfg_valid = 1'b0;
	color_t    cfg_color = '0;

	assign cmd.valid   = req_valid;
	assign cmd.kind    = req_offer.kind;
	assign cmd.start_x = req_offer.sx;
	assign cmd.start_y = req_offer.sy;
	assign cmd.end_x   = req_offer.ex;
	assign cmd.end_y   = req_offer.ey;
	assign pix.ready   = pix_take;
	assign cfg.valid   = cfg_valid;
	assign cfg.draw_color = cfg_color;

	// Requests waiting for the driver, pixels waiting for the monitor.
	line_req_t line_requests[$];
	pixel_t    pending_pixels[$];

	// Line state of the predictor, updated once per accepted request; starts idle.
	int     pen_x, pen_y, goal_x, goal_y;
	int     run_x, rise_neg, slope_err;
	bit     back_x, back_y;
	bit     line_busy = 1'b0;
	color_t paint_color;

	// Idling controls; written by the stimulus block only.
	bit send_gaps_on  = 1'b1;
	bit take_gaps_on  = 1'b1;
	bit long_hold_arm = 1'b0;

	int fail_count = 0;
	int cycle_count = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	// Reset held low from time 0, released once.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Predictor: apply one accepted request, queue the pixel it yields (if any).
	function automatic void advance_line(line_req_t r);
		int     dx, dy, e2, lin;
		bit     at_end;
		pixel_t px;
		if (r.kind == KIND_START) begin
			// A start always reloads, abandoning any line in progress.
			dx = int'(r.ex) - int'(r.sx);
			dy = int'(r.ey) - int'(r.sy);
			run_x     = (dx < 0) ? -dx : dx;
			rise_neg  = (dy < 0) ? dy : -dy;
			back_x    = (dx <= 0);
			back_y    = (dy <= 0);
			slope_err = run_x + rise_neg;
			pen_x  = int'(r.sx);
			pen_y  = int'(r.sy);
			goal_x = int'(r.ex);
			goal_y = int'(r.ey);
		end else begin
			// Step while idle: accepted, no pixel.
			if (!line_busy)
				return;
			e2 = 2 * slope_err;
			if (e2 >= rise_neg) begin
				slope_err += rise_neg;
				pen_x += back_x ? -1 : 1;
			end
			if (e2 <= run_x) begin
				slope_err += run_x;
				pen_y += back_y ? -1 : 1;
			end
		end
		at_end    = (pen_x == goal_x) && (pen_y == goal_y);
		line_busy = !at_end;
		px.x    = pen_x[COORD_W-1:0];
		px.y    = pen_y[COORD_W-1:0];
		px.last = at_end;
		px.on_screen = (pen_x >= 0) && (pen_x < SCREEN_W) && (pen_y >= 0) && (pen_y < SCREEN_H);
		if (px.on_screen) begin
			lin = pen_y * SCREEN_W + pen_x;
			px.byte_offset = BYTE_OFFSET_W'(lin >> PIX_PER_BYTE_LOG2);
			px.bit_mask    = 8'd1 << (MASK_MSB - pen_x[PIX_PER_BYTE_LOG2-1:0]);
			px.plane_bits  = paint_color;
		end else begin
			// Off-screen: nothing written, address fields zero.
			px.byte_offset = '0;
			px.bit_mask    = '0;
			px.plane_bits  = '0;
		end
		pending_pixels.push_back(px);
	endfunction

	task automatic match_pixel_field(string name, logic signed [31:0] want,
		logic signed [31:0] got);
		if (got !== want) begin
			$display("%0t: pixel %s mismatch, expected %0d actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (pending_pixels.size() == 0) begin
			$display("%0t: pixel with none expected, expected nothing actual x=%0d y=%0d",
				$time, pix.pixel_x, pix.pixel_y);
			fail_count++;
			return;
		end
		want = pending_pixels.pop_front();
		match_pixel_field("pixel_x", want.x, pix.pixel_x);
		match_pixel_field("pixel_y", want.y, pix.pixel_y);
		match_pixel_field("on_screen", want.on_screen, pix.on_screen);
		match_pixel_field("byte_offset", want.byte_offset, pix.byte_offset);
		match_pixel_field("bit_mask", want.bit_mask, pix.bit_mask);
		match_pixel_field("plane_bits", want.plane_bits, pix.plane_bits);
		match_pixel_field("last", want.last, pix.last);
	endtask

	// Request driver: holds an offer until taken, then pulls the next one or idles.
	always @(posedge clk) begin : request_driver
		int send_gap;
		if (!arst_n) begin
			req_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (cmd.valid && cmd.ready)
				advance_line(req_offer);
			// A pending offer that was not taken stays up untouched.
			if (!(cmd.valid && !cmd.ready)) begin
				if (send_gap != 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (send_gaps_on && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 15);
					req_valid <= 1'b0;
				end else if (line_requests.size() != 0) begin
					req_offer <= line_requests.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Pixel monitor: checks each taken pixel; random ready gaps plus one long hold-off.
	always @(posedge clk) begin : pixel_monitor
		int take_gap;
		int hold_left;
		bit hold_done;
		if (!arst_n) begin
			pix_take <= 1'b0;
			take_gap  = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (pix.valid && pix.ready)
				check_pixel();
			if (long_hold_arm && !hold_done) begin
				hold_left = LONG_HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				// Long stall: the generator backs up and must stall its request side.
				hold_left--;
				pix_take <= 1'b0;
			end else if (take_gap != 0) begin
				take_gap--;
				pix_take <= 1'b0;
			end else if (take_gaps_on && $urandom_range(0, 9) == 0) begin
				take_gap = $urandom_range(0, 15);
				pix_take <= 1'b0;
			end else begin
				pix_take <= 1'b1;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bresenham_line_planar_pixels_core regression: fail");
			$finish;
		end
	end

	// Queue a start plus n_steps step requests; returns how many of them draw a pixel.
	function automatic int add_line(int sx, int sy, int ex, int ey, int n_steps);
		line_req_t r;
		int        len, k, ax, ay;
		r.kind = KIND_START;
		r.sx = COORD_W'(sx);
		r.sy = COORD_W'(sy);
		r.ex = COORD_W'(ex);
		r.ey = COORD_W'(ey);
		line_requests.push_back(r);
		for (k = 0; k < n_steps; k++) begin
			// Endpoint fields are don't-care on a step; fill with noise.
			r.kind = KIND_STEP;
			r.sx = COORD_W'($urandom);
			r.sy = COORD_W'($urandom);
			r.ex = COORD_W'($urandom);
			r.ey = COORD_W'($urandom);
			line_requests.push_back(r);
		end
		ax  = (ex > sx) ? ex - sx : sx - ex;
		ay  = (ey > sy) ? ey - sy : sy - ey;
		len = (ax > ay) ? ax : ay;
		return 1 + ((n_steps < len) ? n_steps : len);
	endfunction

	// Mostly around the screen, some anywhere, some hugging the coordinate limits.
	function automatic int pick_axis(int screen_len);
		logic signed [COORD_W-1:0] raw;
		int pick;
		pick = $urandom_range(0, 9);
		raw  = COORD_W'($urandom);
		if (pick < 6)
			return int'($urandom_range(0, screen_len + 15)) - 8;
		if (pick < 8)
			return int'(raw);
		if ($urandom_range(0, 1))
			return COORD_MAX - int'($urandom_range(0, 8));
		return COORD_MIN + int'($urandom_range(0, 8));
	endfunction

	function automatic int clamp_coord(int v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	// One random line: usually run to its end, sometimes overstepped, sometimes cut short.
	function automatic int add_random_line();
		int sx, sy, ex, ey, span, dx, dy, ax, ay, len, mode, n;
		sx = pick_axis(SCREEN_W);
		sy = pick_axis(SCREEN_H);
		mode = $urandom_range(0, 39);
		span = (mode == 0) ? 200 : (mode < 8) ? 60 : 12;
		dx = int'($urandom_range(0, 2 * span)) - span;
		dy = int'($urandom_range(0, 2 * span)) - span;
		if ($urandom_range(0, 19) == 0) begin
			// degenerate line: single pixel
			dx = 0;
			dy = 0;
		end
		ex  = clamp_coord(sx + dx);
		ey  = clamp_coord(sy + dy);
		ax  = (ex > sx) ? ex - sx : sx - ex;
		ay  = (ey > sy) ? ey - sy : sy - ey;
		len = (ax > ay) ? ax : ay;
		mode = $urandom_range(0, 19);
		if (mode < 15)
			n = len;
		else if (mode < 17)
			n = len + $urandom_range(1, 3);
		else
			n = $urandom_range(0, len);
		return add_line(sx, sy, ex, ey, n);
	endfunction

	// Sender side waits for every request taken and every pixel back, then lets the pipe settle.
	// Checked at the falling edge, once the rising-edge updates have all landed.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (line_requests.size() != 0 || req_valid || pending_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Color write; only called with the generator idle.
	task automatic write_color(color_t c);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_color <= c;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg_valid <= 1'b0;
		paint_color = c;
	endtask

	initial begin : stimulus
		int     produced;
		int     ph;
		color_t ph_color;
		paint_color = '0;
		wait (arst_n === 1'b1);

		// Directed: all-ones color, octants, screen edges, coordinate extremes.
		write_color(4'hF);
		void'(add_line(0, 0, 0, 0, 1));          // single pixel, then a step while idle
		void'(add_line(637, 477, 641, 481, 4));  // runs off the bottom-right corner
		void'(add_line(COORD_MIN, COORD_MAX, COORD_MIN + 2, COORD_MAX - 3, 3));
		void'(add_line(COORD_MAX, COORD_MIN, COORD_MAX - 2, COORD_MIN + 1, 2));
		void'(add_line(8, 3, 15, 3, 1));         // cut short by the next start
		void'(add_line(20, 30, 19, 26, 4));      // steep, both directions negative
		void'(add_line(-1, -1, 1, 0, 2));        // enters the screen from off-screen
		wait_idle();

		// Random phases; the second one carries the long receiver hold-off,
		// the last one runs with no idling on either side.
		for (ph = 0; ph < 5; ph++) begin
			ph_color = (ph == 0) ? 4'h0 : color_t'($urandom);
			write_color(ph_color);
			send_gaps_on = (ph != 1) && (ph != 4);
			take_gaps_on = (ph != 4);
			if (ph == 1)
				long_hold_arm = 1'b1;
			produced = 0;
			while (produced < RAND_ITEMS_PER_PHASE)
				produced += add_random_line();
			wait_idle();
		end

		if (fail_count == 0) begin
			$display("bresenham_line_planar_pixels_core regression: pass");
		end else begin
			$display("bresenham_line_planar_pixels_core regression: fail");
		end
		$finish;
	end

endmodule
